// ===== src/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the floppy transfer supervisor: event and
// result records, codes and digital output register values.
// ----------------------------------------------------------------------------
`default_nettype none

package fts_pkg;

	// event kinds
	typedef enum logic [2:0] {
		KIND_BEGIN_POSITION  = 3'd0,
		KIND_POSITION_RESULT = 3'd1,
		KIND_BEGIN_TRANSFER  = 3'd2,
		KIND_TRANSFER_RESULT = 3'd3,
		KIND_TICK            = 3'd4
	} kind_t;

	// result actions
	typedef enum logic [2:0] {
		ACT_ACK       = 3'd0,
		ACT_RETRY     = 3'd1,
		ACT_DONE      = 3'd2,
		ACT_EXHAUSTED = 3'd3,
		ACT_WPROT     = 3'd4
	} action_t;

	// motor modes
	typedef enum logic [1:0] {
		MOTOR_OFF  = 2'd0,
		MOTOR_ON   = 2'd1,
		MOTOR_HOLD = 2'd2
	} motor_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_POSITION_RETRY_LIMIT = 3'd0,
		REG_TRANSFER_RETRY_LIMIT = 3'd1,
		REG_MOTOR_HOLD_TIME      = 3'd2,
		REG_TICK_AMOUNT          = 3'd3,
		REG_EXPECTED_SIZE_CODE   = 3'd4
	} reg_index_t;

	localparam int unsigned CFG_DATA_W = 10;

	// digital output register values
	localparam logic [7:0] DOR_MOTOR_ON  = 8'h1c;
	localparam logic [7:0] DOR_MOTOR_OFF = 8'h0c;

	// status bit masks
	localparam logic [7:0] ST0_CLASS     = 8'hc0;
	localparam logic [7:0] ST0_EQUIP     = 8'h08;
	localparam logic [7:0] ST1_END_CYL   = 8'h80;
	localparam logic [7:0] ST1_DATA_ERR  = 8'h20;
	localparam logic [7:0] ST1_OVERRUN   = 8'h10;
	localparam logic [7:0] ST1_NO_DATA   = 8'h04;
	localparam logic [7:0] ST1_WPROT     = 8'h02;
	localparam logic [7:0] ST12_MISS_AM  = 8'h01;
	localparam logic [7:0] ST2_CTRL_MARK = 8'h40;
	localparam logic [7:0] ST2_DATA_CRC  = 8'h20;
	localparam logic [7:0] ST2_WRONG_CYL = 8'h10;
	localparam logic [7:0] ST2_SCAN_NS   = 8'h04;
	localparam logic [7:0] ST2_BAD_CYL   = 8'h02;

	// reset values of the configuration registers
	localparam logic [4:0] RST_POSITION_RETRY_LIMIT = 5'd10;
	localparam logic [4:0] RST_TRANSFER_RETRY_LIMIT = 5'd20;
	localparam logic [9:0] RST_MOTOR_HOLD_TIME      = 10'd300;
	localparam logic [9:0] RST_TICK_AMOUNT          = 10'd50;
	localparam logic [2:0] RST_EXPECTED_SIZE_CODE   = 3'd2;

	localparam logic [4:0] ATTEMPT_MAX = 5'd31;

	// one event item
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] target_cylinder;
		logic [7:0] status0;
		logic [7:0] status1;
		logic [7:0] status2;
		logic [7:0] reported_cylinder;
		logic [7:0] size_code;
	} item_t;

	// one result item
	typedef struct packed {
		logic [2:0]  action;
		logic        dor_write;
		logic [7:0]  dor_value;
		logic        spin_up_wait;
		logic [1:0]  motor_state;
		logic [4:0]  attempt_count;
		logic [12:0] error_flags;
	} result_t;

endpackage

`default_nettype wire

// ===== src/floppy_transfer_supervisor.sv =====
// ----------------------------------------------------------------------------
// floppy_transfer_supervisor
// Judges positioning and transfer results, counts retries and runs the
// drive motor on/hold/off sequence, one event item per transfer.
// ----------------------------------------------------------------------------
// results are registered as events leave the input register; throughput: one
// event per cycle unless results stall, set by the single state update stage
// an event is taken while an earlier result still waits in the output register
// reset: motor off, countdown, attempt count and target cleared, registers
// at their defaults; no clearing pass, events are taken right after reset
`default_nettype none

module floppy_transfer_supervisor (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// event channel
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire fts_pkg::item_t  item,
	// result channel
	output logic                 result_valid,
	input  wire logic            result_stall,
	output fts_pkg::result_t     result,
	// configuration write channel
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [fts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fts_pkg::*;

	// configuration registers
	logic [4:0] position_retry_limit_q;
	logic [4:0] transfer_retry_limit_q;
	logic [9:0] motor_hold_time_q;
	logic [9:0] tick_amount_q;
	logic [2:0] expected_size_code_q;

	// supervisor state
	motor_t      motor_mode_q, motor_mode_d;
	logic [10:0] hold_countdown_q, hold_countdown_d;
	logic [4:0]  attempts_done_q, attempts_done_d;
	logic [7:0]  stored_target_q, stored_target_d;

	// pipeline registers
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_d;
	result_t result_next;

	logic advance;
	logic take;

	// decoded event helpers
	logic [4:0]  attempts_inc;
	logic [12:0] flags;
	logic        release_motor;
	logic        begin_op;
	logic        tick_expire;

	assign cfg_ready    = 1'b1;
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign take         = item_valid && !item_stall;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_retry_limit_q <= RST_POSITION_RETRY_LIMIT;
			transfer_retry_limit_q <= RST_TRANSFER_RETRY_LIMIT;
			motor_hold_time_q      <= RST_MOTOR_HOLD_TIME;
			tick_amount_q          <= RST_TICK_AMOUNT;
			expected_size_code_q   <= RST_EXPECTED_SIZE_CODE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_POSITION_RETRY_LIMIT: position_retry_limit_q <= cfg_data[4:0];
				REG_TRANSFER_RETRY_LIMIT: transfer_retry_limit_q <= cfg_data[4:0];
				REG_MOTOR_HOLD_TIME:      motor_hold_time_q      <= cfg_data;
				REG_TICK_AMOUNT:          tick_amount_q          <= cfg_data;
				REG_EXPECTED_SIZE_CODE:   expected_size_code_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// saturating attempt count and transfer failure flags
	always_comb begin
		attempts_inc = (attempts_done_q < ATTEMPT_MAX) ? attempts_done_q + 5'd1
			: attempts_done_q;
		flags[0]  = |(item_s1.status0 & ST0_CLASS);
		flags[1]  = |(item_s1.status1 & ST1_END_CYL);
		flags[2]  = |(item_s1.status0 & ST0_EQUIP);
		flags[3]  = |(item_s1.status1 & ST1_DATA_ERR);
		flags[4]  = |(item_s1.status1 & ST1_OVERRUN);
		flags[5]  = |(item_s1.status1 & ST1_NO_DATA);
		flags[6]  = |((item_s1.status1 | item_s1.status2) & ST12_MISS_AM);
		flags[7]  = |(item_s1.status2 & ST2_CTRL_MARK);
		flags[8]  = |(item_s1.status2 & ST2_DATA_CRC);
		flags[9]  = |(item_s1.status2 & ST2_WRONG_CYL);
		flags[10] = |(item_s1.status2 & ST2_SCAN_NS);
		flags[11] = |(item_s1.status2 & ST2_BAD_CYL);
		flags[12] = item_s1.size_code != {5'd0, expected_size_code_q};
	end

	// result judgment
	always_comb begin
		result_d      = '0;
		release_motor = 1'b0;
		begin_op      = 1'b0;
		tick_expire   = 1'b0;
		case (item_s1.kind)
			KIND_BEGIN_POSITION, KIND_BEGIN_TRANSFER: begin
				begin_op = 1'b1;
				if (motor_mode_q == MOTOR_OFF) begin
					result_d.dor_write    = 1'b1;
					result_d.dor_value    = DOR_MOTOR_ON;
					result_d.spin_up_wait = 1'b1;
				end
			end
			KIND_POSITION_RESULT: begin
				if (!(|(item_s1.status0 & ST0_CLASS))
					&& item_s1.reported_cylinder == stored_target_q) begin
					result_d.action = ACT_DONE;
					release_motor   = 1'b1;
				end else if (attempts_inc >= position_retry_limit_q) begin
					result_d.action = ACT_EXHAUSTED;
					release_motor   = 1'b1;
				end else begin
					result_d.action = ACT_RETRY;
				end
			end
			KIND_TRANSFER_RESULT: begin
				result_d.error_flags = flags;
				if (|(item_s1.status1 & ST1_WPROT)) begin
					result_d.action = ACT_WPROT;
					release_motor   = 1'b1;
				end else if (flags == '0) begin
					result_d.action = ACT_DONE;
					release_motor   = 1'b1;
				end else if (attempts_inc >= transfer_retry_limit_q) begin
					result_d.action = ACT_EXHAUSTED;
					release_motor   = 1'b1;
				end else begin
					result_d.action = ACT_RETRY;
				end
			end
			KIND_TICK: begin
				if (motor_mode_q == MOTOR_HOLD
					&& hold_countdown_q <= {1'b0, tick_amount_q}) begin
					tick_expire        = 1'b1;
					result_d.dor_write = 1'b1;
					result_d.dor_value = DOR_MOTOR_OFF;
				end
			end
			default: ;
		endcase
	end

	// result fields that follow the state update
	always_comb begin
		result_next               = result_d;
		result_next.motor_state   = motor_mode_d;
		result_next.attempt_count = attempts_done_d;
	end

	// motor next state
	always_comb begin
		motor_mode_d = motor_mode_q;
		if (begin_op) begin
			motor_mode_d = MOTOR_ON;
		end else if (release_motor) begin
			motor_mode_d = MOTOR_HOLD;
		end else if (tick_expire) begin
			motor_mode_d = MOTOR_OFF;
		end
	end

	// countdown, attempt count and target next values
	always_comb begin
		hold_countdown_d = hold_countdown_q;
		attempts_done_d  = attempts_done_q;
		stored_target_d  = stored_target_q;
		case (item_s1.kind)
			KIND_BEGIN_POSITION: begin
				stored_target_d = item_s1.target_cylinder;
				attempts_done_d = '0;
			end
			KIND_BEGIN_TRANSFER: attempts_done_d = '0;
			KIND_POSITION_RESULT, KIND_TRANSFER_RESULT: attempts_done_d = attempts_inc;
			KIND_TICK: begin
				if (tick_expire) begin
					hold_countdown_d = '0;
				end else if (motor_mode_q == MOTOR_HOLD) begin
					hold_countdown_d = hold_countdown_q - {1'b0, tick_amount_q};
				end
			end
			default: ;
		endcase
		if (release_motor) begin
			hold_countdown_d = {1'b0, motor_hold_time_q};
		end
	end

	// state update as an event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_mode_q     <= MOTOR_OFF;
			hold_countdown_q <= '0;
			attempts_done_q  <= '0;
			stored_target_q  <= '0;
		end else if (advance) begin
			motor_mode_q     <= motor_mode_d;
			hold_countdown_q <= hold_countdown_d;
			attempts_done_q  <= attempts_done_d;
			stored_target_q  <= stored_target_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

endmodule

`default_nettype wire

// ===== src/fts_checker.sv =====
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks of the floppy transfer supervisor result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire fts_pkg::result_t  result
);
	import fts_pkg::*;

	// a spin-up wait always comes with the motor-on write
	a_spin_up: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.spin_up_wait |->
			result.dor_write && result.dor_value == DOR_MOTOR_ON
			&& result.motor_state == MOTOR_ON)
		else $error("spin-up wait without motor-on write");

	// every end of an operation leaves the motor in hold
	a_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.action == ACT_DONE || result.action == ACT_EXHAUSTED
			|| result.action == ACT_WPROT) |-> result.motor_state == MOTOR_HOLD)
		else $error("operation ended without motor hold");

	// the motor-off write leaves the motor off
	a_off_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dor_write && result.dor_value == DOR_MOTOR_OFF |->
			result.motor_state == MOTOR_OFF && result.action == ACT_ACK)
		else $error("motor-off write with motor not off");

	// a stalled result transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind floppy_transfer_supervisor fts_checker u_fts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// ===== tb/fts_result_checker.sv =====
// ----------------------------------------------------------------------------
// fts_result_checker
// Watches the event, result and configuration channels of the floppy
// transfer supervisor, keeps its own copy of the motor, retry and target
// state, works out the result of every event transfer and compares each
// result transfer against the oldest outstanding expectation.
// ----------------------------------------------------------------------------

module fts_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  fts_pkg::item_t                 item,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  fts_pkg::result_t               result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [2:0]                     cfg_index,
	input  logic [fts_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             pending,
	output int                             mismatch_count
);
	import fts_pkg::*;

	// register copy
	logic [4:0]  pos_limit;
	logic [4:0]  xfer_limit;
	logic [9:0]  hold_time;
	logic [9:0]  tick_step;
	logic [2:0]  size_expected;

	// supervisor state copy
	motor_t      motor;
	logic [10:0] countdown;
	logic [4:0]  attempts;
	logic [7:0]  target;

	// results still owed by the block, oldest first
	result_t     due_results[$];

	// motor on; a cold start asks for the on pattern and a spin-up wait
	function automatic void start_motor(inout result_t r);
		if (motor == MOTOR_OFF) begin
			r.dor_write    = 1'b1;
			r.dor_value    = DOR_MOTOR_ON;
			r.spin_up_wait = 1'b1;
		end
		motor = MOTOR_ON;
	endfunction

	// end of an operation, motor goes into the hold countdown
	function automatic void release_motor();
		countdown = {1'b0, hold_time};
		motor     = MOTOR_HOLD;
	endfunction

	// state update and result of one event
	function automatic result_t supervise_event(input item_t ev);
		result_t     r;
		logic [12:0] flags;
		r     = '0;
		flags = '0;
		case (ev.kind)
			KIND_BEGIN_POSITION: begin
				target   = ev.target_cylinder;
				attempts = '0;
				start_motor(r);
			end
			KIND_POSITION_RESULT: begin
				if (attempts != ATTEMPT_MAX)
					attempts = attempts + 5'd1;
				if ((ev.status0 & ST0_CLASS) == 8'd0 && ev.reported_cylinder == target) begin
					r.action = ACT_DONE;
					release_motor();
				end else if (attempts >= pos_limit) begin
					r.action = ACT_EXHAUSTED;
					release_motor();
				end else begin
					r.action = ACT_RETRY;
				end
			end
			KIND_BEGIN_TRANSFER: begin
				attempts = '0;
				start_motor(r);
			end
			KIND_TRANSFER_RESULT: begin
				if (attempts != ATTEMPT_MAX)
					attempts = attempts + 5'd1;
				flags[0]  = |(ev.status0 & ST0_CLASS);
				flags[1]  = |(ev.status1 & ST1_END_CYL);
				flags[2]  = |(ev.status0 & ST0_EQUIP);
				flags[3]  = |(ev.status1 & ST1_DATA_ERR);
				flags[4]  = |(ev.status1 & ST1_OVERRUN);
				flags[5]  = |(ev.status1 & ST1_NO_DATA);
				flags[6]  = |((ev.status1 | ev.status2) & ST12_MISS_AM);
				flags[7]  = |(ev.status2 & ST2_CTRL_MARK);
				flags[8]  = |(ev.status2 & ST2_DATA_CRC);
				flags[9]  = |(ev.status2 & ST2_WRONG_CYL);
				flags[10] = |(ev.status2 & ST2_SCAN_NS);
				flags[11] = |(ev.status2 & ST2_BAD_CYL);
				flags[12] = ev.size_code != {5'd0, size_expected};
				// write protect ends the transfer whatever else is flagged
				if ((ev.status1 & ST1_WPROT) != 8'd0) begin
					r.action = ACT_WPROT;
					release_motor();
				end else if (flags == '0) begin
					r.action = ACT_DONE;
					release_motor();
				end else if (attempts >= xfer_limit) begin
					r.action = ACT_EXHAUSTED;
					release_motor();
				end else begin
					r.action = ACT_RETRY;
				end
			end
			KIND_TICK: begin
				if (motor == MOTOR_HOLD) begin
					if (countdown <= {1'b0, tick_step}) begin
						countdown   = '0;
						motor       = MOTOR_OFF;
						r.dor_write = 1'b1;
						r.dor_value = DOR_MOTOR_OFF;
					end else begin
						countdown = countdown - {1'b0, tick_step};
					end
				end
			end
			default: begin
			end
		endcase
		r.motor_state   = motor;
		r.attempt_count = attempts;
		r.error_flags   = flags;
		return r;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int      bad;
		if (!arst_n) begin
			pos_limit     = RST_POSITION_RETRY_LIMIT;
			xfer_limit    = RST_TRANSFER_RETRY_LIMIT;
			hold_time     = RST_MOTOR_HOLD_TIME;
			tick_step     = RST_TICK_AMOUNT;
			size_expected = RST_EXPECTED_SIZE_CODE;
			motor         = MOTOR_OFF;
			countdown     = '0;
			attempts      = '0;
			target        = '0;
			due_results.delete();
			pending        <= 0;
			mismatch_count <= 0;
		end else begin
			bad = 0;
			// results first: an event taken at this edge cannot be answered yet
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					bad = 1;
					if (mismatch_count < 10)
						$display("unexpected result transfer: action %0d motor %0d attempts %0d",
							result.action, result.motor_state, result.attempt_count);
				end else begin
					want = due_results.pop_front();
					if (result.action !== want.action || result.dor_write !== want.dor_write ||
						result.dor_value !== want.dor_value ||
						result.spin_up_wait !== want.spin_up_wait ||
						result.motor_state !== want.motor_state ||
						result.attempt_count !== want.attempt_count ||
						result.error_flags !== want.error_flags) begin
						bad = 1;
						if (mismatch_count < 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected: action %0d dor %0b/%02h spin %0b motor %0d att %0d flags %04h",
								want.action, want.dor_write, want.dor_value, want.spin_up_wait,
								want.motor_state, want.attempt_count, want.error_flags);
							$display("  actual:   action %0d dor %0b/%02h spin %0b motor %0d att %0d flags %04h",
								result.action, result.dor_write, result.dor_value, result.spin_up_wait,
								result.motor_state, result.attempt_count, result.error_flags);
						end
					end
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_POSITION_RETRY_LIMIT: pos_limit     = cfg_data[4:0];
					REG_TRANSFER_RETRY_LIMIT: xfer_limit    = cfg_data[4:0];
					REG_MOTOR_HOLD_TIME:      hold_time     = cfg_data[9:0];
					REG_TICK_AMOUNT:          tick_step     = cfg_data[9:0];
					REG_EXPECTED_SIZE_CODE:   size_expected = cfg_data[2:0];
					default: begin
					end
				endcase
			end
			// event transfers
			if (item_valid && !item_stall)
				due_results.push_back(supervise_event(item));
			pending        <= due_results.size();
			mismatch_count <= mismatch_count + bad;
		end
	end

endmodule

// ===== tb/tb_floppy_transfer_supervisor.sv =====
// ----------------------------------------------------------------------------
// tb_floppy_transfer_supervisor
// Drives positioning and transfer sequences, motor ticks and noise into the
// floppy transfer supervisor under several register settings, with random
// gaps and stalls on both channels; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------

module tb_floppy_transfer_supervisor;
	import fts_pkg::*;

	// event codes the block ignores
	localparam logic [2:0] KIND_SPARE_A = 3'd5;
	localparam logic [2:0] KIND_SPARE_B = 3'd6;
	localparam logic [2:0] KIND_SPARE_C = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [2:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    pending;
	int                    mismatch_count;

	// shared with the receiver
	logic                  calm;
	int                    holdoff_requests;

	// what the generator knows about the current settings
	logic [4:0]            pos_limit;
	logic [4:0]            xfer_limit;
	logic [2:0]            size_expected;
	logic [7:0]            target_now;
	int                    items_sent;

	floppy_transfer_supervisor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	fts_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending        (pending),
		.mismatch_count (mismatch_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	// result side: random stalls plus long hold-offs on request
	initial begin
		int hold_left;
		int holdoffs_served;
		hold_left       = 0;
		holdoffs_served = 0;
		result_stall    = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoffs_served != holdoff_requests) begin
				holdoffs_served = holdoff_requests;
				hold_left       = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 36);
			end
		end
	end

	function automatic item_t compose(input logic [2:0] k, input logic [7:0] tgt,
		input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
		input logic [7:0] rc, input logic [7:0] sz);
		item_t ev;
		ev.kind              = k;
		ev.target_cylinder   = tgt;
		ev.status0           = s0;
		ev.status1           = s1;
		ev.status2           = s2;
		ev.reported_cylinder = rc;
		ev.size_code         = sz;
		return ev;
	endfunction

	function automatic item_t random_event(input logic [2:0] k);
		return compose(k, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endfunction

	// position result that succeeds or fails on purpose
	function automatic item_t position_result(input bit good);
		item_t ev;
		ev = random_event(KIND_POSITION_RESULT);
		if (good) begin
			ev.status0           = ev.status0 & ~ST0_CLASS;
			ev.reported_cylinder = target_now;
		end else if ($urandom_range(1) == 0) begin
			ev.status0 = ev.status0 | (ST0_CLASS & 8'($urandom_range(1, 3) << 6));
		end else begin
			ev.reported_cylinder = target_now ^ 8'($urandom_range(1, 255));
		end
		return ev;
	endfunction

	// transfer result: clean, failing, or write protected
	function automatic item_t transfer_result(input bit good, input bit wprot);
		item_t ev;
		ev = random_event(KIND_TRANSFER_RESULT);
		if (good) begin
			ev.status0   = ev.status0 & ~(ST0_CLASS | ST0_EQUIP);
			ev.status1   = ev.status1 & ~(ST1_END_CYL | ST1_DATA_ERR | ST1_OVERRUN |
				ST1_NO_DATA | ST1_WPROT | ST12_MISS_AM);
			ev.status2   = ev.status2 & ~(ST2_CTRL_MARK | ST2_DATA_CRC | ST2_WRONG_CYL |
				ST2_SCAN_NS | ST2_BAD_CYL | ST12_MISS_AM);
			ev.size_code = {5'd0, size_expected};
		end else begin
			// sparse status bytes make single flags show up alone
			if ($urandom_range(1) == 0) begin
				ev.status0 = 8'd0;
				ev.status1 = 8'd0;
				ev.status2 = 8'd0;
				ev.size_code = {5'd0, size_expected};
			end
			ev.status1 = ev.status1 & ~ST1_WPROT;
			case ($urandom_range(2))
				0: ev.status2 = ev.status2 | ST2_DATA_CRC;
				1: ev.size_code = {5'd0, size_expected + 3'($urandom_range(1, 7))};
				default: ev.size_code = 8'($urandom_range(8, 255));
			endcase
			if (wprot)
				ev.status1 = ev.status1 | ST1_WPROT;
		end
		return ev;
	endfunction

	// one event transfer, with random idle cycles ahead of it
	task automatic offer_event(input item_t ev);
		while (!calm && $urandom_range(99) < 36) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= ev;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (ev.kind == KIND_BEGIN_POSITION)
			target_now = ev.target_cylinder;
		if (ev.kind <= KIND_TICK)
			items_sent++;
	endtask

	// stop sending until every result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic cfg_step(input reg_index_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// all five registers, only while the block is idle
	task automatic apply_settings(input logic [4:0] pl, input logic [4:0] xl,
		input logic [9:0] ht, input logic [9:0] ta, input logic [2:0] sc);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_step(REG_POSITION_RETRY_LIMIT, 10'(pl));
		cfg_step(REG_TRANSFER_RETRY_LIMIT, 10'(xl));
		cfg_step(REG_MOTOR_HOLD_TIME, ht);
		cfg_step(REG_TICK_AMOUNT, ta);
		cfg_step(REG_EXPECTED_SIZE_CODE, 10'(sc));
		cfg_valid     <= 1'b0;
		pos_limit     = pl;
		xfer_limit    = xl;
		size_expected = sc;
	endtask

	// seek or recalibrate, then results until done or out of attempts
	task automatic run_position_op();
		int fails;
		offer_event(compose(KIND_BEGIN_POSITION,
			($urandom_range(3) == 0) ? 8'd0 : 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom)));
		fails = $urandom_range(0, pos_limit + 2);
		for (int n = 1; n <= 40; n++) begin
			if (n > fails) begin
				offer_event(position_result(1'b1));
				break;
			end
			offer_event(position_result(1'b0));
			if (n >= pos_limit)
				break;
		end
	endtask

	// track transfer, then results until done, protected or out of attempts
	task automatic run_transfer_op();
		int fails;
		bit wprot;
		offer_event(random_event(KIND_BEGIN_TRANSFER));
		fails = $urandom_range(0, xfer_limit + 2);
		for (int n = 1; n <= 40; n++) begin
			if (n > fails) begin
				offer_event(transfer_result(1'b1, 1'b0));
				break;
			end
			wprot = $urandom_range(11) == 0;
			offer_event(transfer_result(1'b0, wprot));
			if (wprot || n >= xfer_limit)
				break;
		end
	endtask

	task automatic offer_ticks(input int n);
		repeat (n) offer_event(random_event(KIND_TICK));
	endtask

	// stimulus
	initial begin
		int quota_end;
		int pick;
		arst_n           = 1'b0;
		item_valid       = 1'b0;
		item             = '0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		calm             = 1'b0;
		holdoff_requests = 0;
		pos_limit        = RST_POSITION_RETRY_LIMIT;
		xfer_limit       = RST_TRANSFER_RETRY_LIMIT;
		size_expected    = RST_EXPECTED_SIZE_CODE;
		target_now       = '0;
		items_sent       = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset settings
		offer_event(compose(KIND_SPARE_C, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		offer_event(compose(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_BEGIN_POSITION, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_POSITION_RESULT, 8'h00, 8'h40, 8'h00, 8'h00, 8'hff, 8'h00));
		offer_event(compose(KIND_POSITION_RESULT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hfe, 8'h00));
		offer_event(compose(KIND_POSITION_RESULT, 8'h00, 8'h3f, 8'h00, 8'h00, 8'hff, 8'h00));
		// begin while holding, then write protect over every other flag
		offer_event(compose(KIND_BEGIN_TRANSFER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_TRANSFER_RESULT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		offer_event(compose(KIND_BEGIN_TRANSFER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_TRANSFER_RESULT, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h02));
		offer_event(compose(KIND_TRANSFER_RESULT, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02));
		offer_event(compose(KIND_TRANSFER_RESULT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03));
		offer_event(compose(KIND_TRANSFER_RESULT, 8'h00, 8'h37, 8'h48, 8'h88, 8'h00, 8'h02));
		// hold countdown runs out on the sixth tick
		offer_ticks(6);
		offer_event(compose(KIND_BEGIN_POSITION, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_POSITION_RESULT, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_POSITION_RESULT, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_SPARE_A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		offer_event(compose(KIND_SPARE_B, 8'h5a, 8'ha5, 8'h5a, 8'ha5, 8'h5a, 8'ha5));

		// random part under several settings
		for (int stage_no = 0; stage_no < 8; stage_no++) begin
			case (stage_no)
				1: apply_settings(5'd0, 5'd0, 10'd0, 10'd0, 3'd0);
				2: apply_settings(5'd31, 5'd31, 10'd1023, 10'd1023, 3'd7);
				3: apply_settings(5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)),
					10'($urandom_range(0, 200)), 10'($urandom_range(1, 80)), 3'($urandom));
				0: begin
				end
				default: apply_settings(5'($urandom), 5'($urandom), 10'($urandom),
					10'($urandom_range(1, 1023)), 3'($urandom));
			endcase
			// no idling on either side in one whole stretch
			if (stage_no == 3)
				calm <= 1'b1;
			if (stage_no == 4)
				calm <= 1'b0;
			// receiver holds off while events keep coming
			if (stage_no == 4 || stage_no == 6)
				holdoff_requests <= holdoff_requests + 1;
			quota_end = items_sent + 230;
			while (items_sent < quota_end) begin
				pick = $urandom_range(99);
				if (pick < 42) begin
					run_position_op();
				end else if (pick < 84) begin
					run_transfer_op();
				end else if (pick < 96) begin
					repeat ($urandom_range(1, 10))
						offer_event(random_event(3'($urandom_range(KIND_BEGIN_POSITION,
							KIND_SPARE_C))));
				end else if (pick < 98) begin
					// results with no begin, mostly enough to saturate the attempt count
					repeat ($urandom_range(30, 36))
						offer_event(random_event(($urandom_range(1) == 0) ?
							KIND_POSITION_RESULT : KIND_TRANSFER_RESULT));
				end else begin
					drain_results();
				end
				if ($urandom_range(1) == 0)
					offer_ticks($urandom_range(1, 8));
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
